// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/twrc_pkg.sv =====
// ----------------------------------------------------------------------------
// twrc_pkg
// Types and fixed constants of the TCP window rewrite and checksum core.
// ----------------------------------------------------------------------------
`default_nettype none

package twrc_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_UNITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 2'd2;

	localparam logic [15:0] TARGET_PORT_RST = 16'd5001;
	localparam logic [15:0] WINDOW_UNITS_RST = 16'd1;
	localparam logic [15:0] SEGMENT_SIZE_RST = 16'd1460;

	localparam logic [7:0] PROTO_TCP = 8'd6;

	// IPv4 header byte positions
	localparam logic [15:0] IHL_BYTE = 16'd0;
	localparam logic [15:0] PROTO_BYTE = 16'd9;
	localparam logic [15:0] ADDR_FIRST = 16'd12;
	localparam logic [15:0] ADDR_END = 16'd20;

	// TCP header byte positions, relative to the TCP header start
	localparam logic [15:0] DPORT_HI_OFS = 16'd2;
	localparam logic [15:0] DPORT_LO_OFS = 16'd3;
	localparam logic [15:0] WIN_FIRST_OFS = 16'd14;
	localparam logic [15:0] CHK_LAST_OFS = 16'd17;
	localparam logic [15:0] TCP_HDR_BYTES = 16'd20;

	localparam logic [3:0] MIN_IHL = 4'd5;

	// Packet state after the current byte has been taken in
	typedef struct packed {
		logic [15:0] byte_count;
		logic [3:0]  header_words;
		logic [7:0]  protocol_number;
		logic [15:0] destination_port;
		logic [31:0] running_sum;
		logic [7:0]  pending_high_byte;
	} snap_t;

endpackage

`default_nettype wire

// ===== rtl/twrc_pkt_if.sv =====
// ----------------------------------------------------------------------------
// twrc_pkt_if
// Byte stream of an outgoing IPv4 packet, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface twrc_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/twrc_patch_if.sv =====
// ----------------------------------------------------------------------------
// twrc_patch_if
// Patch request for one packet, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface twrc_patch_if;
	logic        valid;
	logic        ready;
	logic        rewrite;
	logic [15:0] new_window;
	logic [15:0] new_checksum;
	logic [5:0]  tcp_offset;
	logic [15:0] packet_length;
	logic        malformed;

	modport source (
		output valid, output rewrite, output new_window, output new_checksum,
		output tcp_offset, output packet_length, output malformed, input ready
	);
	modport sink (
		input valid, input rewrite, input new_window, input new_checksum,
		input tcp_offset, input packet_length, input malformed, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tcp_window_rewrite_checksum_core.sv =====
// ----------------------------------------------------------------------------
// tcp_window_rewrite_checksum_core
// Rewrites the TCP receive window of packets to one port and recomputes
// the TCP checksum, one packet byte per cycle unless a last byte is held back.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | accepted when
//  pkt      | in  | data_byte, last_byte                            | valid & ready
//  patch    | out | rewrite, new_window, new_checksum, tcp_offset,  | valid & ready
//           |     | packet_length, malformed                        |
//  cfg      | in  | cfg_index, cfg_wdata                            | cfg_wr_en
//
// One byte is taken every cycle unless a last byte is held back. The patch request
// for a packet passes, after its last byte is taken into the input register, through the
// header/sum snapshot, final pseudo-header add, carry fold into the output register.
// A stalled patch channel holds the output register; bytes that are not last
// keep flowing until a last byte finds the sum stages full.
// Reset clears the valid flags, configuration and parser state at once; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module tcp_window_rewrite_checksum_core #(
	parameter int unsigned MAX_PACKET_BYTES = 65535
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	twrc_pkt_if.sink                                 pkt,
	twrc_patch_if.source                             patch,
	input  wire logic                                cfg_wr_en,
	input  wire logic [twrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [twrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// configuration
	logic [15:0] target_port_q;
	logic [15:0] window_units_q;
	logic [15:0] segment_size_q;
	logic [15:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_port_q <= twrc_pkg::TARGET_PORT_RST;
			window_units_q <= twrc_pkg::WINDOW_UNITS_RST;
			segment_size_q <= twrc_pkg::SEGMENT_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				twrc_pkg::CFG_TARGET_PORT: target_port_q <= cfg_wdata;
				twrc_pkg::CFG_WINDOW_UNITS: window_units_q <= cfg_wdata;
				twrc_pkg::CFG_SEGMENT_SIZE: segment_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// window is taken mod 65536, so only the low product bits are kept
	logic [15:0] win_prod;
	assign win_prod = window_units_q * segment_size_q;

	always_ff @(posedge clk) begin
		win_q <= win_prod;
	end

	// handshake chain
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic last_s1;
	logic [7:0] data_s1;
	logic out_free, s3_ready, s2_ready, s1_go;

	assign out_free = !out_valid_q || patch.ready;
	assign s3_ready = !valid_s3 || out_free;
	assign s2_ready = !valid_s2 || s3_ready;
	assign s1_go = valid_s1 && (!last_s1 || s2_ready);
	assign pkt.ready = !valid_s1 || !last_s1 || s2_ready;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	twrc_pkg::snap_t snap;

	twrc_byte_parser #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (s1_go),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.snap     (snap)
	);

	// stage 2: packet snapshot on the last byte
	twrc_pkg::snap_t snap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_go && last_s1) begin
			snap_s2 <= snap;
		end
	end

	logic [15:0] toff2;
	logic [15:0] tcp_len2;
	logic        bad2;
	logic        rw2;
	logic [31:0] sum2;

	assign toff2 = {10'd0, snap_s2.header_words, 2'b00};
	assign tcp_len2 = snap_s2.byte_count - toff2;
	assign bad2 = snap_s2.header_words < twrc_pkg::MIN_IHL ||
		(snap_s2.protocol_number == twrc_pkg::PROTO_TCP &&
			snap_s2.byte_count < toff2 + twrc_pkg::TCP_HDR_BYTES);
	assign rw2 = !bad2 && snap_s2.protocol_number == twrc_pkg::PROTO_TCP &&
		snap_s2.destination_port == target_port_q;
	assign sum2 = snap_s2.running_sum + {16'd0, snap_s2.pending_high_byte, 8'h00} +
		{24'd0, snap_s2.protocol_number} + {16'd0, tcp_len2} + {16'd0, win_q};

	// stage 3: raw pseudo-header sum
	logic [31:0] sum_s3;
	logic        rw_s3;
	logic        bad_s3;
	logic [5:0]  toff_s3;
	logic [15:0] len_s3;
	logic [15:0] win_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && valid_s2) begin
			sum_s3 <= sum2;
			rw_s3 <= rw2;
			bad_s3 <= bad2;
			toff_s3 <= toff2[5:0];
			len_s3 <= snap_s2.byte_count;
			win_s3 <= win_q;
		end
	end

	// fold carries twice, then complement
	logic [16:0] fold1;
	logic [15:0] fold2;
	assign fold1 = {1'b0, sum_s3[15:0]} + {1'b0, sum_s3[31:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

	// output register
	logic        rewrite_q;
	logic [15:0] new_window_q;
	logic [15:0] new_checksum_q;
	logic [5:0]  tcp_offset_q;
	logic [15:0] packet_length_q;
	logic        malformed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			rewrite_q <= rw_s3;
			new_window_q <= rw_s3 ? win_s3 : 16'd0;
			new_checksum_q <= rw_s3 ? ~fold2 : 16'd0;
			tcp_offset_q <= toff_s3;
			packet_length_q <= len_s3;
			malformed_q <= bad_s3;
		end
	end

	assign patch.valid = out_valid_q;
	assign patch.rewrite = rewrite_q;
	assign patch.new_window = new_window_q;
	assign patch.new_checksum = new_checksum_q;
	assign patch.tcp_offset = tcp_offset_q;
	assign patch.packet_length = packet_length_q;
	assign patch.malformed = malformed_q;

	`ASSERT_SAME(a_no_patch_zero, clk, arst_n, patch.valid && !patch.rewrite,
		patch.new_window == 16'd0 && patch.new_checksum == 16'd0, "patch values on skip")
	`ASSERT_SAME(a_rewrite_wellformed, clk, arst_n, patch.valid && patch.rewrite,
		!patch.malformed && patch.tcp_offset >= 6'd20 &&
		patch.packet_length >= 16'(patch.tcp_offset) + 16'd20,
		"rewrite on malformed packet")
	`ASSERT_NEXT(a_s3_held, clk, arst_n, valid_s3 && !out_free,
		valid_s3 && $stable(sum_s3), "sum stage lost while stalled")

endmodule

`default_nettype wire

// ===== rtl/twrc_byte_parser.sv =====
// ----------------------------------------------------------------------------
// twrc_byte_parser
// Per-byte header capture and running ones-complement word sum.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twrc_byte_parser #(
	parameter int unsigned MAX_PACKET_BYTES = 65535
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic [7:0]     data_byte,
	input  wire logic           last_byte,
	output twrc_pkg::snap_t     snap
);

	twrc_pkg::snap_t st_q;
	twrc_pkg::snap_t nx;

	logic [15:0] idx;
	logic [15:0] toff;
	logic [15:0] rel;
	logic        active;
	logic        inc;
	logic [7:0]  bval;

	assign idx = st_q.byte_count;
	assign active = idx < 16'(MAX_PACKET_BYTES);

	always_comb begin
		nx = st_q;
		if (idx == twrc_pkg::IHL_BYTE) begin
			nx.header_words = data_byte[3:0];
		end
		if (idx == twrc_pkg::PROTO_BYTE) begin
			nx.protocol_number = data_byte;
		end
		toff = {10'd0, nx.header_words, 2'b00};
		rel = idx - toff;
		if (idx == toff + twrc_pkg::DPORT_HI_OFS) begin
			nx.destination_port = {data_byte, st_q.destination_port[7:0]};
		end
		if (idx == toff + twrc_pkg::DPORT_LO_OFS) begin
			nx.destination_port = {st_q.destination_port[15:8], data_byte};
		end
		// addresses always count; the TCP part counts except window and check
		inc = (idx >= twrc_pkg::ADDR_FIRST && idx < twrc_pkg::ADDR_END) ||
			(idx >= toff && !(rel >= twrc_pkg::WIN_FIRST_OFS &&
				rel <= twrc_pkg::CHK_LAST_OFS));
		bval = inc ? data_byte : 8'h00;
		if (!idx[0]) begin
			nx.pending_high_byte = bval;
		end else begin
			nx.running_sum = st_q.running_sum + {16'd0, st_q.pending_high_byte, bval};
			nx.pending_high_byte = 8'h00;
		end
		nx.byte_count = idx + 16'd1;
		// past the length limit: drop the byte
		if (!active) begin
			nx = st_q;
		end
	end

	assign snap = nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= last_byte ? '0 : nx;
		end
	end

	`ASSERT_SAME(a_count_limit, clk, arst_n, 1'b1,
		st_q.byte_count <= 16'(MAX_PACKET_BYTES), "byte count beyond limit")
	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, en && last_byte,
		st_q.byte_count == 16'd0 && st_q.running_sum == 32'd0, "state not cleared")
	`ASSERT_SAME(a_pending_odd, clk, arst_n, st_q.byte_count[0] == 1'b0 && active,
		st_q.pending_high_byte == 8'h00, "high byte left at word boundary")

endmodule

`default_nettype wire

// ===== test/tb_tcp_window_rewrite_checksum_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_window_rewrite_checksum_core
// Streams IPv4 packets byte by byte into the window rewrite core and checks
// every patch request against a byte-level predictor or a typed table entry. A short table of
// directed packets comes first, then random packets over several settings.
// ----------------------------------------------------------------------------
module tb_tcp_window_rewrite_checksum_core;

	localparam int unsigned MAX_PKT = 65535;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned RANDOM_BYTES = 1260;
	localparam int unsigned PHASES = 6;
	localparam int unsigned MIN_PHASE_PKTS = 4;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	typedef struct packed {
		logic        rewrite;
		logic [15:0] new_window;
		logic [15:0] new_checksum;
		logic [5:0]  tcp_offset;
		logic [15:0] packet_length;
		logic        malformed;
	} patch_t;

	// Running state of the packet currently streaming in
	typedef struct packed {
		logic [15:0] count;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] dport;
		logic [31:0] sum;
		logic [7:0]  high;
	} flow_t;

	typedef struct {
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] dport;
		int unsigned len;
		fill_t       fill;
		bit          zero_chk;
		bit          typed;
		patch_t      want;
	} row_t;

	typedef struct {
		bit     typed;
		patch_t want;
	} plan_t;

	localparam patch_t NO_PATCH = '0;

	// Typed expectations: rewrite, window, checksum, tcp offset, length, malformed
	row_t directed_rows [14] = '{
		'{4'd0,  8'd0,   16'd0,     1, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd0,  16'd1,  1'b1}},
		'{4'd4,  8'd6,   16'd5001, 20, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd16, 16'd20, 1'b1}},
		'{4'd5,  8'd17,  16'd5001, 28, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd20, 16'd28, 1'b0}},
		'{4'd5,  8'd6,   16'd5001, 39, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd20, 16'd39, 1'b1}},
		'{4'd5,  8'd6,   16'd5001, 40, FILL_RANDOM, 1'b0, 1'b0, NO_PATCH},
		'{4'd5,  8'd6,   16'd5002, 60, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd20, 16'd60, 1'b0}},
		'{4'd15, 8'd6,   16'd5001, 80, FILL_RANDOM, 1'b0, 1'b0, NO_PATCH},
		'{4'd5,  8'd6,   16'd5001, 41, FILL_RANDOM, 1'b0, 1'b0, NO_PATCH},
		'{4'd15, 8'd255, 16'hFFFF, 64, FILL_ONES,   1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd60, 16'd64, 1'b0}},
		'{4'd5,  8'd6,   16'd5001, 48, FILL_RANDOM, 1'b1, 1'b0, NO_PATCH},
		'{4'd5,  8'd6,   16'd5001, 40, FILL_ZEROS,  1'b0, 1'b0, NO_PATCH},
		'{4'd15, 8'd17,  16'd5001, 60, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd60, 16'd60, 1'b0}},
		'{4'd0,  8'd6,   16'd5001, 40, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd0,  16'd40, 1'b1}},
		'{4'd15, 8'd6,   16'd5001, 79, FILL_RANDOM, 1'b0, 1'b1, '{1'b0, 16'd0, 16'd0, 6'd60, 16'd79, 1'b1}}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [twrc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [twrc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	twrc_pkt_if   pkt_ch ();
	twrc_patch_if patch_ch ();

	tcp_window_rewrite_checksum_core #(
		.MAX_PACKET_BYTES(MAX_PKT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.patch(patch_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [15:0] port_reg = twrc_pkg::TARGET_PORT_RST;
	logic [15:0] units_reg = twrc_pkg::WINDOW_UNITS_RST;
	logic [15:0] seg_reg = twrc_pkg::SEGMENT_SIZE_RST;

	flow_t      flow = '0;
	patch_t     expected_patches[$];
	plan_t      packet_plan[$];
	logic [7:0] frame[$];

	int mismatches = 0;
	int results_seen = 0;
	int rewrites_seen = 0;
	int zero_sums_seen = 0;
	int malformed_seen = 0;
	int packets_sent = 0;
	int bytes_sent = 0;
	int settings_used = 1;
	int idle_cycles = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic flow_t fold_in_byte(flow_t s, logic [7:0] b);
		int unsigned idx;
		int unsigned toff;
		bit inc;
		idx = s.count;
		if (idx >= MAX_PKT)
			return s;
		if (idx == twrc_pkg::IHL_BYTE)
			s.ihl = b[3:0];
		if (idx == twrc_pkg::PROTO_BYTE)
			s.proto = b;
		toff = s.ihl * 4;
		if (idx == toff + twrc_pkg::DPORT_HI_OFS)
			s.dport[15:8] = b;
		if (idx == toff + twrc_pkg::DPORT_LO_OFS)
			s.dport[7:0] = b;
		// addresses always count; window and check words of the TCP header never do
		if (idx >= twrc_pkg::ADDR_FIRST && idx < twrc_pkg::ADDR_END)
			inc = 1'b1;
		else if (idx >= toff)
			inc = !(idx - toff >= twrc_pkg::WIN_FIRST_OFS &&
				idx - toff <= twrc_pkg::CHK_LAST_OFS);
		else
			inc = 1'b0;
		if (idx % 2 == 0) begin
			s.high = inc ? b : 8'h00;
		end else begin
			s.sum = s.sum + {16'h0000, s.high, (inc ? b : 8'h00)};
			s.high = 8'h00;
		end
		s.count = 16'(idx + 1);
		return s;
	endfunction

	function automatic patch_t patch_from(flow_t s);
		int unsigned toff;
		int unsigned len;
		logic [31:0] acc;
		logic [15:0] win;
		patch_t p;
		toff = s.ihl * 4;
		len = s.count;
		p = '0;
		p.malformed = (s.ihl < twrc_pkg::MIN_IHL) ||
			(s.proto == twrc_pkg::PROTO_TCP && len < toff + twrc_pkg::TCP_HDR_BYTES);
		p.rewrite = !p.malformed && s.proto == twrc_pkg::PROTO_TCP && s.dport == port_reg;
		win = 16'(units_reg * seg_reg);
		if (p.rewrite) begin
			// pad an odd last byte, add pseudo-header and the new window
			acc = s.sum + {16'h0000, s.high, 8'h00} + {24'h0, s.proto} + ((len - toff) & 32'hFFFF)
				+ {16'h0000, win};
			acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
			acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
			p.new_window = win;
			p.new_checksum = ~acc[15:0];
		end
		p.tcp_offset = 6'(toff);
		p.packet_length = 16'(len);
		return p;
	endfunction

	function automatic void compose(logic [3:0] ihl, logic [7:0] proto, logic [15:0] dport,
		int unsigned len, fill_t fill);
		int unsigned toff;
		logic [7:0] b;
		frame.delete();
		toff = ihl * 4;
		for (int unsigned i = 0; i < len; i++) begin
			case (fill)
				FILL_ONES: b = 8'hFF;
				FILL_ZEROS: b = 8'h00;
				default: b = 8'($urandom);
			endcase
			if (i == twrc_pkg::IHL_BYTE)
				b[3:0] = ihl;
			if (i == twrc_pkg::PROTO_BYTE)
				b = proto;
			if (i == toff + twrc_pkg::DPORT_HI_OFS)
				b = dport[15:8];
			if (i == toff + twrc_pkg::DPORT_LO_OFS)
				b = dport[7:0];
			frame.push_back(b);
		end
	endfunction

	// Put the complement of the sum into the last payload word, so the checksum folds to zero
	function automatic void zero_out_checksum();
		flow_t s;
		patch_t p;
		int unsigned n;
		n = frame.size();
		frame[n-2] = 8'h00;
		frame[n-1] = 8'h00;
		s = '0;
		foreach (frame[i])
			s = fold_in_byte(s, frame[i]);
		p = patch_from(s);
		frame[n-2] = p.new_checksum[15:8];
		frame[n-1] = p.new_checksum[7:0];
	endfunction

	task automatic send_byte(logic [7:0] b, bit last, int unsigned gap);
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.data_byte <= b;
		pkt_ch.last_byte <= last;
		do @(posedge clk); while (!pkt_ch.ready);
		bytes_sent++;
	endtask

	task automatic ship(bit typed, patch_t want, bit calm);
		int unsigned n;
		plan_t entry;
		n = frame.size();
		entry.typed = typed;
		entry.want = want;
		packet_plan.push_back(entry);
		for (int unsigned i = 0; i < n; i++)
			send_byte(frame[i], i == n - 1, calm ? 0 : $urandom_range(0, 19));
		packets_sent++;
	endtask

	// Hold the byte stream until every patch request is back, then let the pipe empty
	task automatic settle();
		pkt_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_patches.size() != 0 || packet_plan.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [twrc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			twrc_pkg::CFG_TARGET_PORT: port_reg = val;
			twrc_pkg::CFG_WINDOW_UNITS: units_reg = val;
			twrc_pkg::CFG_SEGMENT_SIZE: seg_reg = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [15:0] port, logic [15:0] units, logic [15:0] seg);
		settle();
		write_reg(twrc_pkg::CFG_TARGET_PORT, port);
		write_reg(twrc_pkg::CFG_WINDOW_UNITS, units);
		write_reg(twrc_pkg::CFG_SEGMENT_SIZE, seg);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic random_packet();
		logic [3:0] ihl;
		logic [7:0] proto;
		int unsigned kind;
		int unsigned toff;
		int unsigned len;
		bit calm;
		kind = $urandom_range(0, 15);
		ihl = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(5, 15)) : twrc_pkg::MIN_IHL;
		toff = ihl * 4;
		calm = $urandom_range(0, 3) == 0;
		if (kind <= 8 || kind == 15) begin
			len = toff + twrc_pkg::TCP_HDR_BYTES + ((kind == 15) ? 0 : $urandom_range(0, 40));
			compose(ihl, twrc_pkg::PROTO_TCP, port_reg, len, FILL_RANDOM);
			if (len % 2 == 0 && len >= toff + twrc_pkg::TCP_HDR_BYTES + 2
				&& $urandom_range(0, 5) == 0)
				zero_out_checksum();
		end else if (kind <= 10) begin
			compose(ihl, twrc_pkg::PROTO_TCP, port_reg ^ 16'($urandom_range(1, 65535)),
				toff + twrc_pkg::TCP_HDR_BYTES + $urandom_range(0, 30), FILL_RANDOM);
		end else if (kind == 11) begin
			// TCP header cut short
			compose(ihl, twrc_pkg::PROTO_TCP, port_reg,
				$urandom_range(10, toff + twrc_pkg::TCP_HDR_BYTES - 1), FILL_RANDOM);
		end else if (kind == 12) begin
			proto = 8'($urandom);
			if (proto == twrc_pkg::PROTO_TCP)
				proto = ~proto;
			compose(ihl, proto, port_reg, $urandom_range(20, 70), FILL_RANDOM);
		end else if (kind == 13) begin
			proto = ($urandom_range(0, 1) == 0) ? twrc_pkg::PROTO_TCP : 8'($urandom);
			compose(4'($urandom_range(0, 4)), proto, port_reg, $urandom_range(1, 50), FILL_RANDOM);
		end else begin
			compose(4'($urandom), 8'($urandom), 16'($urandom), $urandom_range(1, 30), FILL_RANDOM);
		end
		ship(1'b0, NO_PATCH, calm);
	endtask

	// Predict on every accepted byte, check every accepted patch request
	always @(posedge clk) begin
		plan_t entry;
		patch_t got;
		patch_t want;
		if (arst_n) begin
			if (pkt_ch.valid && pkt_ch.ready) begin
				flow = fold_in_byte(flow, pkt_ch.data_byte);
				if (pkt_ch.last_byte) begin
					entry = packet_plan.pop_front();
					expected_patches.push_back(entry.typed ? entry.want : patch_from(flow));
					flow = '0;
				end
			end
			if (patch_ch.valid && patch_ch.ready) begin
				got = {patch_ch.rewrite, patch_ch.new_window, patch_ch.new_checksum,
					patch_ch.tcp_offset, patch_ch.packet_length, patch_ch.malformed};
				results_seen++;
				rewrites_seen += got.rewrite;
				malformed_seen += got.malformed;
				if (got.rewrite && got.new_checksum == 16'h0000)
					zero_sums_seen++;
				if (expected_patches.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("patch %0d: unexpected request rw=%0d win=%h chk=%h off=%0d len=%0d bad=%0d",
							results_seen, got.rewrite, got.new_window, got.new_checksum,
							got.tcp_offset, got.packet_length, got.malformed);
				end else begin
					want = expected_patches.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("patch %0d: expected rw=%0d win=%h chk=%h off=%0d len=%0d bad=%0d",
								results_seen, want.rewrite, want.new_window, want.new_checksum,
								want.tcp_offset, want.packet_length, want.malformed);
							$display("patch %0d:      got rw=%0d win=%h chk=%h off=%0d len=%0d bad=%0d",
								results_seen, got.rewrite, got.new_window, got.new_checksum,
								got.tcp_offset, got.packet_length, got.malformed);
						end
					end
				end
			end
		end
	end

	// Patch side: stall each request for a random number of cycles, with calm stretches
	initial begin
		int unsigned stall;
		int unsigned served;
		bit calm;
		patch_ch.ready = 1'b0;
		served = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (served % 8 == 0)
				calm = $urandom_range(0, 3) == 0;
			stall = calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				patch_ch.ready <= 1'b0;
				do @(posedge clk); while (!patch_ch.valid);
				repeat (stall - 1) @(posedge clk);
			end
			patch_ch.ready <= 1'b1;
			do @(posedge clk); while (!patch_ch.valid);
			served++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pkt_ch.valid && pkt_ch.ready) || (patch_ch.valid && patch_ch.ready)
			|| cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("stalled for %0d cycles with %0d patch requests outstanding",
				idle_cycles, expected_patches.size());
			$display("[tcp_window_rewrite_checksum_core] ERROR");
			$finish;
		end
	end

	initial begin
		int start_bytes;
		int start_pkts;
		row_t row;
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.data_byte = 8'h00;
		pkt_ch.last_byte = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = twrc_pkg::CFG_TARGET_PORT;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			compose(row.ihl, row.proto, row.dport, row.len, row.fill);
			if (row.zero_chk)
				zero_out_checksum();
			ship(row.typed, row.want, $urandom_range(0, 3) == 0);
		end

		start_bytes = bytes_sent;
		start_pkts = packets_sent;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_settings(16'h0000, 16'h0000, 16'h0000);
				1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: apply_settings(twrc_pkg::TARGET_PORT_RST, twrc_pkg::WINDOW_UNITS_RST,
					twrc_pkg::SEGMENT_SIZE_RST);
				3: apply_settings(16'($urandom), 16'($urandom), 16'd1);
				4: apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
				default: apply_settings(16'($urandom), 16'd1, 16'hFFFF);
			endcase
			while (bytes_sent - start_bytes < (p + 1) * RANDOM_BYTES / PHASES
				|| packets_sent - start_pkts < (p + 1) * MIN_PHASE_PKTS) begin
				random_packet();
				if ($urandom_range(0, 11) == 0)
					settle();
			end
		end
		settle();

		$display("run covered %0d packets, %0d bytes, %0d register settings",
			packets_sent, bytes_sent, settings_used);
		$display("patch requests: %0d checked, %0d rewritten, %0d zero checksum, %0d malformed",
			results_seen, rewrites_seen, zero_sums_seen, malformed_seen);
		if (mismatches == 0)
			$display("[tcp_window_rewrite_checksum_core] OK");
		else
			$display("[tcp_window_rewrite_checksum_core] ERROR");
		$finish;
	end

endmodule
